FILE: hw/rtl/vgle_pkg.sv
// Shared types and constants for the voxel gradient / Laplacian extrema block.
// No dependencies; imported by vgle_isqrt and voxel_gradient_laplacian_extrema.
package vgle_pkg;

    localparam int VALUE_LEVELS = 256;
    localparam int IDX_W        = (VALUE_LEVELS > 1) ? $clog2(VALUE_LEVELS) : 1;

    localparam int VOXEL_W  = 8;
    localparam int GRAD_W   = 12;
    localparam int LAP_W    = 12;
    localparam int MAXG_W   = 8;
    localparam int SQ_W     = 16;
    localparam int SUM_W    = 18;
    localparam int NBR_W    = 11;
    localparam int RAD_W    = 24;
    localparam int ROOT_W   = 12;
    localparam int REM_W    = 15;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int STEP_W   = $clog2(ROOT_STEPS);

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [VOXEL_W-1:0] center;
        logic [VOXEL_W-1:0] x_plus;
        logic [VOXEL_W-1:0] x_minus;
        logic [VOXEL_W-1:0] y_plus;
        logic [VOXEL_W-1:0] y_minus;
        logic [VOXEL_W-1:0] z_plus;
        logic [VOXEL_W-1:0] z_minus;
        logic [VOXEL_W-1:0] table_index;
    } voxel_t;

    typedef struct packed {
        logic [GRAD_W-1:0]        gradient_q4;
        logic signed [LAP_W-1:0]  laplacian;
        logic [MAXG_W-1:0]        max_gradient;
        logic signed [LAP_W-1:0]  min_laplacian;
        logic signed [LAP_W-1:0]  max_laplacian;
        logic                     entry_seen;
    } result_t;

    typedef struct packed {
        logic [MAXG_W-1:0]        max_gradient;
        logic signed [LAP_W-1:0]  min_laplacian;
        logic signed [LAP_W-1:0]  max_laplacian;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ROOT,
        S_UPDATE,
        S_REPLY
    } state_t;

endpackage

FILE: hw/rtl/voxel_gradient_laplacian_extrema.sv
// Top level of the voxel gradient / Laplacian extrema block.
// Depends on vgle_pkg and vgle_isqrt.
//
// Takes one voxel with its six axis neighbours (operation 0) and returns the
// central-difference gradient magnitude in unsigned Q8.4 together with the
// 7-point Laplacian, while updating the entry of the centre value in a
// 256-entry extrema table (rounded maximum gradient, minimum and maximum
// Laplacian); the result also carries that entry after the update.
// Operation 1 returns the entry of table_index. The table sits in one
// synchronous RAM with a registered read port; per-entry seen flags are
// flip-flops cleared by reset, so no clearing pass is needed. A voxel passes
// through a fetch state, the 12-step square-root unit, a wait for it to finish
// and an update state that loads the result once the output is free; a read
// passes through the fetch state and a reply state. One transaction is in
// work at a time, and a new one is accepted while the previous result still
// waits at the output.
module voxel_gradient_laplacian_extrema (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              voxel_valid,
    output logic              voxel_ready,
    input  vgle_pkg::voxel_t  voxel,
    output logic              result_valid,
    input  logic              result_ready,
    output vgle_pkg::result_t result
);
    import vgle_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    voxel_t  item_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    entry_t  mem [VALUE_LEVELS];
    entry_t  rd_data_reg;
    entry_t  entry_next;
    logic [VALUE_LEVELS-1:0] seen_reg;
    logic signed [LAP_W-1:0] lap_reg;

    logic                    out_free;
    logic                    mem_re;
    logic                    mem_we;
    logic                    root_start;
    logic                    load_result;
    logic                    root_busy;
    logic                    root_done;
    logic [ROOT_W-1:0]       root;

    logic [VOXEL_W-1:0]      idx_sel;
    logic [IDX_W-1:0]        addr;
    logic                    in_range;
    logic                    seen;

    logic signed [VOXEL_W:0] dx;
    logic signed [VOXEL_W:0] dy;
    logic signed [VOXEL_W:0] dz;
    logic signed [2*VOXEL_W+1:0] sq_x;
    logic signed [2*VOXEL_W+1:0] sq_y;
    logic signed [2*VOXEL_W+1:0] sq_z;
    logic [SUM_W-1:0]        sum_sq;
    logic [NBR_W-1:0]        nbr_sum;
    logic [NBR_W-1:0]        six_c;
    logic signed [LAP_W-1:0] lap;

    logic [MAXG_W-1:0]       old_grad;
    logic [MAXG_W-1:0]       grad_round;
    logic [ROOT_W-3:0]       round_sum;

    // Squared differences and the Laplacian of the held neighbourhood
    always_comb
    begin
        dx   = $signed({1'b0, item_reg.x_plus}) - $signed({1'b0, item_reg.x_minus});
        dy   = $signed({1'b0, item_reg.y_plus}) - $signed({1'b0, item_reg.y_minus});
        dz   = $signed({1'b0, item_reg.z_plus}) - $signed({1'b0, item_reg.z_minus});
        sq_x = dx * dx;
        sq_y = dy * dy;
        sq_z = dz * dz;
        sum_sq = SUM_W'(sq_x[SQ_W-1:0]) + SUM_W'(sq_y[SQ_W-1:0])
               + SUM_W'(sq_z[SQ_W-1:0]);
        nbr_sum = NBR_W'(item_reg.x_plus) + NBR_W'(item_reg.x_minus)
                + NBR_W'(item_reg.y_plus) + NBR_W'(item_reg.y_minus)
                + NBR_W'(item_reg.z_plus) + NBR_W'(item_reg.z_minus);
        six_c   = NBR_W'({item_reg.center, 2'b00}) + NBR_W'({item_reg.center, 1'b0});
        lap     = $signed(LAP_W'(nbr_sum)) - $signed(LAP_W'(six_c));
    end

    vgle_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({sum_sq, 6'b000000}),
        .busy     (root_busy),
        .done     (root_done),
        .root     (root)
    );

    assign idx_sel  = (item_reg.operation == OP_READ) ? item_reg.table_index : item_reg.center;
    assign in_range = (int'(idx_sel) < VALUE_LEVELS);
    assign addr     = idx_sel[IDX_W-1:0];
    assign seen     = in_range && seen_reg[addr];
    assign out_free = !result_valid_reg || result_ready;

    // Round the true gradient: isqrt(S) is the Q8.4 root shifted down by three
    assign round_sum  = (ROOT_W-2)'(root[ROOT_W-1:3]) + (ROOT_W-2)'(1);
    assign grad_round = MAXG_W'(round_sum >> 1);
    assign old_grad   = seen ? rd_data_reg.max_gradient : '0;

    always_comb
    begin
        entry_next.max_gradient = (grad_round > old_grad) ? grad_round : old_grad;
        if (seen)
        begin
            entry_next.min_laplacian = (lap_reg < rd_data_reg.min_laplacian)
                                     ? lap_reg : rd_data_reg.min_laplacian;
            entry_next.max_laplacian = (lap_reg > rd_data_reg.max_laplacian)
                                     ? lap_reg : rd_data_reg.max_laplacian;
        end
        else
        begin
            entry_next.min_laplacian = lap_reg;
            entry_next.max_laplacian = lap_reg;
        end
    end

    always_comb
    begin
        result_next = '0;
        if (item_reg.operation == OP_READ)
        begin
            if (seen)
            begin
                result_next.max_gradient  = rd_data_reg.max_gradient;
                result_next.min_laplacian = rd_data_reg.min_laplacian;
                result_next.max_laplacian = rd_data_reg.max_laplacian;
                result_next.entry_seen    = 1'b1;
            end
        end
        else
        begin
            result_next.gradient_q4 = root;
            result_next.laplacian   = lap_reg;
            if (in_range)
            begin
                result_next.max_gradient  = entry_next.max_gradient;
                result_next.min_laplacian = entry_next.min_laplacian;
                result_next.max_laplacian = entry_next.max_laplacian;
                result_next.entry_seen    = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (voxel_valid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = (item_reg.operation == OP_READ) ? S_REPLY : S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE, S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        voxel_ready = 1'b0;
        mem_re      = 1'b0;
        root_start  = 1'b0;
        load_result = 1'b0;
        mem_we      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                voxel_ready = 1'b1;
            end
            S_FETCH:
            begin
                mem_re     = 1'b1;
                root_start = (item_reg.operation == OP_PROCESS);
            end
            S_ROOT:
            begin
                root_start = 1'b0;
            end
            S_UPDATE:
            begin
                load_result = out_free;
                mem_we      = out_free && in_range;
            end
            S_REPLY:
            begin
                load_result = out_free;
            end
            default:
            begin
                voxel_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            seen_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                seen_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (voxel_valid && voxel_ready)
        begin
            item_reg <= voxel;
        end
        if (root_start)
        begin
            lap_reg <= lap;
        end
        if (load_result)
        begin
            result_reg <= result_next;
        end
    end

    // Extrema table: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= entry_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_accept_fetch : assert property (@(posedge clk) disable iff (!rst_n)
        voxel_valid && voxel_ready |=> state_reg == S_FETCH)
        else $error("accepted transaction did not advance to fetch");

    a_root_idle_on_start : assert property (@(posedge clk) disable iff (!rst_n)
        root_start |-> !root_busy)
        else $error("square root restarted while busy");

    a_done_in_root : assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == S_ROOT)
        else $error("square root finished outside the root wait");

    a_write_sets_seen : assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> seen_reg[$past(addr)])
        else $error("table write left the entry unseen");
`endif

endmodule

FILE: hw/rtl/vgle_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on vgle_pkg for widths.
module vgle_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vgle_pkg::RAD_W-1:0]  radicand,
    output logic                        busy,
    output logic                        done,
    output logic [vgle_pkg::ROOT_W-1:0] root
);
    import vgle_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [STEP_W-1:0] count_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + STEP_W'(1);
                if (count_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: tb/voxel_gradient_laplacian_extrema_tb.sv
// Testbench for voxel_gradient_laplacian_extrema: directed and random voxel and read
// transactions, checked against a gradient / Laplacian / extrema-table predictor.
// Depends on vgle_pkg and the block's RTL only.
`timescale 1ns / 100ps

import vgle_pkg::*;

class voxel_extrema_board;
    bit [MAXG_W-1:0] peak_grad [VALUE_LEVELS];
    int              lap_lo [VALUE_LEVELS];
    int              lap_hi [VALUE_LEVELS];
    bit              value_seen [VALUE_LEVELS];
    result_t         pending_results [$];
    int              mismatches;

    function int unsigned floor_root(int unsigned v);
        int unsigned r = 0;
        for (int b = 12; b >= 0; b--)
        begin
            if ((r | (1 << b)) * (r | (1 << b)) <= v)
                r = r | (1 << b);
        end
        return r;
    endfunction

    // Predict the result of an accepted transaction and apply its table update.
    function void note_voxel(voxel_t v);
        result_t             want;
        int                  dx, dy, dz, lap;
        int unsigned         sq, rounded;
        logic [IDX_W-1:0]    idx;
        want = '0;
        if (v.operation == OP_READ)
        begin
            idx = v.table_index;
        end
        else
        begin
            dx  = int'(v.x_plus) - int'(v.x_minus);
            dy  = int'(v.y_plus) - int'(v.y_minus);
            dz  = int'(v.z_plus) - int'(v.z_minus);
            sq  = dx * dx + dy * dy + dz * dz;
            lap = int'(v.x_plus) + int'(v.x_minus) + int'(v.y_plus) + int'(v.y_minus)
                + int'(v.z_plus) + int'(v.z_minus) - 6 * int'(v.center);
            want.gradient_q4 = GRAD_W'(floor_root(sq * 64));
            want.laplacian   = LAP_W'(lap);
            rounded = (floor_root(sq) + 1) >> 1;
            idx = v.center;
            if (rounded > peak_grad[idx])
                peak_grad[idx] = MAXG_W'(rounded);
            if (!value_seen[idx])
            begin
                lap_lo[idx]     = lap;
                lap_hi[idx]     = lap;
                value_seen[idx] = 1'b1;
            end
            else
            begin
                if (lap < lap_lo[idx])
                    lap_lo[idx] = lap;
                if (lap > lap_hi[idx])
                    lap_hi[idx] = lap;
            end
        end
        want.max_gradient = peak_grad[idx];
        if (value_seen[idx])
        begin
            want.min_laplacian = LAP_W'(lap_lo[idx]);
            want.max_laplacian = LAP_W'(lap_hi[idx]);
            want.entry_seen    = 1'b1;
        end
        pending_results.push_back(want);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: grad %0d lap %0d peak %0d lo %0d hi %0d seen %0d",
                         got.gradient_q4, got.laplacian, got.max_gradient,
                         got.min_laplacian, got.max_laplacian, got.entry_seen);
            return;
        end
        want = pending_results.pop_front();
        if (got.gradient_q4 !== want.gradient_q4 || got.laplacian !== want.laplacian ||
            got.max_gradient !== want.max_gradient ||
            got.min_laplacian !== want.min_laplacian ||
            got.max_laplacian !== want.max_laplacian || got.entry_seen !== want.entry_seen)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("result mismatch: want grad %0d lap %0d peak %0d lo %0d hi %0d seen %0d;",
                       want.gradient_q4, want.laplacian, want.max_gradient,
                       want.min_laplacian, want.max_laplacian, want.entry_seen);
                $display(" got grad %0d lap %0d peak %0d lo %0d hi %0d seen %0d",
                         got.gradient_q4, got.laplacian, got.max_gradient,
                         got.min_laplacian, got.max_laplacian, got.entry_seen);
            end
        end
    endfunction

    function int pending_count();
        return pending_results.size();
    endfunction
endclass

module voxel_gradient_laplacian_extrema_tb;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 1000000;

    logic    clk;
    logic    rst_n;
    logic    voxel_valid;
    logic    voxel_ready;
    voxel_t  voxel;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    voxel_extrema_board board;
    int                 voxels_taken;
    int                 cycle_count;
    int                 burst_left;
    bit                 written [VALUE_LEVELS];
    int                 written_list [$];
    logic [VOXEL_W-1:0] hot [16];

    voxel_gradient_laplacian_extrema dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .voxel_valid  (voxel_valid),
        .voxel_ready  (voxel_ready),
        .voxel        (voxel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (voxel_valid && voxel_ready)
            begin
                board.note_voxel(voxel);
                voxels_taken++;
            end
            if (result_valid && result_ready)
                board.check_result(result);
        end
    end

    // Mostly short lengths, a few long ones.
    function automatic int span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            burst_left = $urandom_range(20, 80);
        return span();
    endfunction

    function automatic logic [VOXEL_W-1:0] jitter(logic [VOXEL_W-1:0] c);
        int t;
        t = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return VOXEL_W'(t);
    endfunction

    function automatic voxel_t proc_item(logic [VOXEL_W-1:0] c, logic [VOXEL_W-1:0] xp,
                                         logic [VOXEL_W-1:0] xm, logic [VOXEL_W-1:0] yp,
                                         logic [VOXEL_W-1:0] ym, logic [VOXEL_W-1:0] zp,
                                         logic [VOXEL_W-1:0] zm);
        voxel_t v;
        v.operation   = OP_PROCESS;
        v.center      = c;
        v.x_plus      = xp;
        v.x_minus     = xm;
        v.y_plus      = yp;
        v.y_minus     = ym;
        v.z_plus      = zp;
        v.z_minus     = zm;
        v.table_index = VOXEL_W'($urandom_range(0, 255));
        if (!written[c])
        begin
            written[c] = 1'b1;
            written_list.push_back(int'(c));
        end
        return v;
    endfunction

    // Read transaction; an entry never seen answers with zero extrema.
    function automatic voxel_t read_item(logic [VOXEL_W-1:0] idx);
        voxel_t v;
        v             = voxel_t'({$urandom, $urandom, $urandom});
        v.operation   = OP_READ;
        v.table_index = idx;
        return v;
    endfunction

    task automatic send_voxel(input voxel_t v);
        int gap;
        int target;
        gap = next_gap();
        if (gap > 0)
        begin
            voxel_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        voxel       = v;
        voxel_valid = 1'b1;
        target      = voxels_taken + 1;
        do
            @(negedge clk);
        while (voxels_taken != target);
    endtask

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 9) == 0)
            begin
                result_ready = 1'b1;
                repeat ($urandom_range(50, 200)) @(negedge clk);
            end
            else
            begin
                result_ready = ($urandom_range(0, 2) != 0);
                repeat (span()) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [VOXEL_W-1:0] c;
        logic [VOXEL_W-1:0] base;
        logic [VOXEL_W-1:0] nb [6];
        int                 r;
        rst_n       = 1'b0;
        voxel_valid = 1'b0;
        voxel       = '0;
        board       = new();
        for (int i = 0; i < 16; i++)
            hot[i] = VOXEL_W'($urandom_range(0, 255));
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Entries read right after reset are unseen.
        send_voxel(read_item(8'd1));
        send_voxel(read_item(8'd255));
        // Field extremes: flat, Laplacian at both ends, steepest gradient both ways.
        send_voxel(proc_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_voxel(proc_item(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_voxel(proc_item(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_voxel(proc_item(8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
        send_voxel(proc_item(8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
        // Gradient below the stored peak leaves it alone.
        send_voxel(proc_item(8'd128, 8'd129, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128));
        // First sighting of a value, then a new minimum, a new maximum, one inside.
        send_voxel(proc_item(8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200));
        send_voxel(proc_item(8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_voxel(proc_item(8'd200, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_voxel(proc_item(8'd200, 8'd210, 8'd210, 8'd210, 8'd210, 8'd210, 8'd210));
        // Half-unit gradients, and one whole one, exercise the rounding of the peak.
        send_voxel(proc_item(8'd50, 8'd1, 8'd0, 8'd50, 8'd50, 8'd50, 8'd50));
        send_voxel(proc_item(8'd50, 8'd2, 8'd0, 8'd50, 8'd50, 8'd50, 8'd50));
        send_voxel(proc_item(8'd50, 8'd50, 8'd50, 8'd3, 8'd0, 8'd50, 8'd50));
        send_voxel(proc_item(8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd0, 8'd5));
        // Alternating bit patterns on the centre and every neighbour.
        send_voxel(proc_item(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_voxel(proc_item(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_voxel(read_item(8'd0));
        send_voxel(read_item(8'd255));
        send_voxel(read_item(8'd128));
        send_voxel(read_item(8'd200));
        send_voxel(read_item(8'd50));
        send_voxel(read_item(8'hAA));
        send_voxel(read_item(8'h55));

        // Most voxels land on a small set of values so their extrema keep moving.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_voxel(read_item(VOXEL_W'($urandom_range(0, 255))));
                else
                    send_voxel(read_item(VOXEL_W'(
                        written_list[$urandom_range(0, written_list.size() - 1)])));
            end
            else
            begin
                c = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 15)]
                                                : VOXEL_W'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0:
                    begin
                        foreach (nb[i])
                            nb[i] = VOXEL_W'($urandom_range(0, 255));
                    end
                    1:
                    begin
                        foreach (nb[i])
                            nb[i] = jitter(c);
                    end
                    2:
                    begin
                        foreach (nb[i])
                            nb[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    end
                    default:
                    begin
                        base = VOXEL_W'($urandom_range(0, 255));
                        foreach (nb[i])
                            nb[i] = base;
                        nb[$urandom_range(0, 5)] = VOXEL_W'($urandom_range(0, 255));
                    end
                endcase
                send_voxel(proc_item(c, nb[0], nb[1], nb[2], nb[3], nb[4], nb[5]));
            end
        end
        voxel_valid = 1'b0;

        // Drain, then give a stray result time to show up.
        while (board.pending_count() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (board.mismatches == 0 && board.pending_count() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/vgle_pkg.sv
hw/rtl/vgle_isqrt.sv
hw/rtl/voxel_gradient_laplacian_extrema.sv
tb/voxel_gradient_laplacian_extrema_tb.sv
